### design/priority_message_queue_top_macros.svh
// Assertion macros for the priority message queue
`ifndef PRIORITY_MESSAGE_QUEUE_TOP_MACROS_SVH
`define PRIORITY_MESSAGE_QUEUE_TOP_MACROS_SVH
// implication checked every clock edge outside reset
`define PMQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pmq check failed");
// next-cycle implication
`define PMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pmq check failed");
`endif

### design/pmq_pkg.sv
// Shared constants and types for the priority message queue
package pmq_pkg;
	localparam int NumPrioDef = 8;
	localparam int DepthDef   = 256;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_DISABLED = 3'd1;
	localparam logic [2:0] ST_BADPRIO  = 3'd2;
	localparam logic [2:0] ST_DROPPED  = 3'd3;
	localparam logic [2:0] ST_EMPTY    = 3'd4;

	localparam logic [1:0] RR_NONE = 2'd0;
	localparam logic [1:0] RR_WARN = 2'd1;
	localparam logic [1:0] RR_FULL = 2'd2;

	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_CAP    = 2'd1;
	localparam logic [1:0] REG_DEST_A = 2'd2;
	localparam logic [1:0] REG_DEST_B = 2'd3;

	typedef struct packed {
		logic        kind;
		logic [31:0] msg_handle;
		logic [3:0]  msg_prio;
		logic [15:0] dest_id;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] handle_out;
		logic [3:0]  prio_out;
		logic [1:0]  reset_request;
		logic [8:0]  occupancy;
		logic [31:0] discards_a;
		logic [31:0] discards_b;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [31:0] data;
	} cfg_item_t;
endpackage

### design/pmq_if.sv
// Valid/ready channel interfaces for the priority message queue
interface pmq_in_if;
	logic                valid;
	logic                ready;
	pmq_pkg::in_item_t   payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface pmq_out_if;
	logic                valid;
	logic                ready;
	pmq_pkg::out_item_t  payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface pmq_cfg_if;
	logic                valid;
	logic                ready;
	pmq_pkg::cfg_item_t  payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### design/priority_message_queue_top.sv
// Priority message queue: linked store with per-level FIFOs and a level scanner
// A queued send steps through decide while the free link is read, write and load result;
// a refused or dropped send goes from decide to load result. A receive scans the levels
// from the scan cursor downward, one level per step, then reads, writes and loads the
// result, and an empty one once no level is left. After reset an initialisation pass
// writes every link before the first item is taken. The sequencer is not ready while it
// works on an item. A result waiting at the output holds the next item in its final step.
module priority_message_queue_top #(
	parameter int NUM_PRIO = pmq_pkg::NumPrioDef,
	parameter int DEPTH    = pmq_pkg::DepthDef
) (
	input  logic clk,
	input  logic arst_n,
	pmq_in_if.sink    in_ch,
	pmq_out_if.source out_ch,
	pmq_cfg_if.sink   cfg
);
	import pmq_pkg::*;
	`include "priority_message_queue_top_macros.svh"

	localparam int AW = $clog2(DEPTH);
	localparam int LW = $clog2(NUM_PRIO);
	localparam int CW = AW + 1;

	localparam logic [2:0] S_INIT = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_SRD  = 3'd2;
	localparam logic [2:0] S_SWR  = 3'd3;
	localparam logic [2:0] S_SCAN = 3'd4;
	localparam logic [2:0] S_RRD  = 3'd5;
	localparam logic [2:0] S_RWR  = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0] state_q;
	logic [AW-1:0] init_q;

	logic        en_q;
	logic [8:0]  cap_q;
	logic [15:0] dest_a_q, dest_b_q;

	logic [31:0] handle_mem [DEPTH];
	logic [AW-1:0] link_mem [DEPTH];
	logic [AW-1:0] link_rd_q;
	logic [31:0] handle_rd_q;

	logic [AW-1:0] free_head_q;
	logic [AW-1:0] lhead_q [NUM_PRIO];
	logic [AW-1:0] ltail_q [NUM_PRIO];
	logic [CW-1:0] lcount_q [NUM_PRIO];
	logic [CW-1:0] held_q;
	logic [LW:0]   cursor_q;
	logic          warn_q;
	logic [31:0]   drop_a_q, drop_b_q;

	in_item_t  item_q;
	logic [LW:0] scan_q;
	logic [AW-1:0] slot_q;
	out_item_t res_q;
	out_item_t out_q;
	logic        res_valid_q;

	// link memory port
	logic          lk_we;
	logic [AW-1:0] lk_wa, lk_wd, lk_ra;
	logic          hd_we;

	logic [LW-1:0] iprio, scan_lv;
	logic [CW:0]   cap_eff;
	logic [CW+5:0] lim, cur;
	logic          drop, over;
	logic          prio_ok, dest_is_a, dest_is_b, bump_a, bump_b;
	logic          load_out;

	assign iprio   = item_q.msg_prio[LW-1:0];
	assign scan_lv = LW'(scan_q - 1'b1);
	assign cap_eff = ({1'b0, cap_q} > (CW+1)'(DEPTH)) ? (CW+1)'(DEPTH) :
		(CW+1)'({1'b0, cap_q});
	assign drop = ((CW+1)'(held_q) + (CW+1)'(10)) >= cap_eff;
	assign lim  = ((CW+6)'(cap_eff) + (CW+6)'(NUM_PRIO + 1)) * (CW+6)'(9);
	assign cur  = ((CW+6)'(held_q) + (CW+6)'(NUM_PRIO + 1)) * (CW+6)'(10);
	assign over = lim < cur;

	assign prio_ok   = {1'b0, item_q.msg_prio} < 5'(NUM_PRIO);
	assign dest_is_a = item_q.dest_id == dest_a_q;
	assign dest_is_b = item_q.dest_id == dest_b_q;
	// the first exempt destination wins when both match
	assign bump_a = en_q && prio_ok && drop && dest_is_a;
	assign bump_b = en_q && prio_ok && drop && !dest_is_a && dest_is_b;

	// move the finished result to the output once it is free
	assign load_out = (state_q == S_DONE) && (!res_valid_q || out_ch.ready);

	assign in_ch.ready  = (state_q == S_IDLE);
	assign cfg.ready    = 1'b1;
	assign out_ch.valid = res_valid_q;
	assign out_ch.payload = out_q;

	always_comb begin
		lk_we = 1'b0;
		lk_wa = init_q;
		lk_wd = AW'(init_q + 1'b1);
		lk_ra = free_head_q;
		hd_we = 1'b0;
		unique case (state_q)
			S_INIT: lk_we = 1'b1;
			S_SRD: lk_ra = free_head_q;
			S_SWR: begin
				hd_we = 1'b1;
				if (lcount_q[iprio] != '0) begin
					lk_we = 1'b1;
					lk_wa = ltail_q[iprio];
					lk_wd = free_head_q;
				end
			end
			S_RRD: lk_ra = slot_q;
			S_RWR: begin
				lk_we = 1'b1;
				lk_wa = slot_q;
				lk_wd = free_head_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (lk_we) link_mem[lk_wa] <= lk_wd;
		link_rd_q <= link_mem[lk_ra];
		if (hd_we) handle_mem[free_head_q] <= item_q.msg_handle;
		handle_rd_q <= handle_mem[slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			init_q <= '0;
			en_q <= 1'b0;
			cap_q <= 9'd256;
			dest_a_q <= 16'd0;
			dest_b_q <= 16'd1;
			free_head_q <= '0;
			for (int i = 0; i < NUM_PRIO; i++) begin
				lhead_q[i] <= '0;
				ltail_q[i] <= '0;
				lcount_q[i] <= '0;
			end
			held_q <= '0;
			cursor_q <= '0;
			warn_q <= 1'b0;
			drop_a_q <= '0;
			drop_b_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.payload.index)
					REG_ENABLE: en_q <= cfg.payload.data[0];
					REG_CAP:    cap_q <= cfg.payload.data[8:0];
					REG_DEST_A: dest_a_q <= cfg.payload.data[15:0];
					REG_DEST_B: dest_b_q <= cfg.payload.data[15:0];
					default: ;
				endcase
			end
			res_valid_q <= load_out || (res_valid_q && !out_ch.ready);
			if (load_out) out_q <= res_q;
			unique case (state_q)
				S_INIT: begin
					init_q <= AW'(init_q + 1'b1);
					if (init_q == AW'(DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						item_q <= in_ch.payload;
						scan_q <= (cursor_q > (LW+1)'(NUM_PRIO)) ? (LW+1)'(NUM_PRIO) :
							cursor_q;
						res_q <= '0;
						state_q <= in_ch.payload.kind ? S_SCAN : S_SRD;
					end
				end
				S_SRD: begin
					res_q.occupancy <= 9'(held_q);
					res_q.discards_a <= drop_a_q + 32'(bump_a);
					res_q.discards_b <= drop_b_q + 32'(bump_b);
					drop_a_q <= drop_a_q + 32'(bump_a);
					drop_b_q <= drop_b_q + 32'(bump_b);
					if (!en_q) begin
						res_q.status <= ST_DISABLED;
						state_q <= S_DONE;
					end else if (!prio_ok) begin
						res_q.status <= ST_BADPRIO;
						state_q <= S_DONE;
					end else if (drop) begin
						res_q.status <= ST_DROPPED;
						if (!dest_is_a && !dest_is_b) res_q.reset_request <= RR_FULL;
						state_q <= S_DONE;
					end else begin
						if (over) begin
							if (!warn_q && !dest_is_a && !dest_is_b) begin
								res_q.reset_request <= RR_WARN;
								warn_q <= 1'b1;
							end
						end else begin
							warn_q <= 1'b0;
						end
						state_q <= S_SWR;
					end
				end
				S_SWR: begin
					free_head_q <= link_rd_q;
					if (lcount_q[iprio] == '0) lhead_q[iprio] <= free_head_q;
					ltail_q[iprio] <= free_head_q;
					lcount_q[iprio] <= lcount_q[iprio] + 1'b1;
					held_q <= held_q + 1'b1;
					res_q.occupancy <= 9'(held_q + 1'b1);
					if (cursor_q < (LW+1)'(iprio) + 1'b1)
						cursor_q <= (LW+1)'(iprio) + 1'b1;
					state_q <= S_DONE;
				end
				S_SCAN: begin
					res_q.occupancy <= 9'(held_q);
					res_q.discards_a <= drop_a_q;
					res_q.discards_b <= drop_b_q;
					if (scan_q == '0) begin
						res_q.status <= ST_EMPTY;
						state_q <= S_DONE;
					end else if (lcount_q[scan_lv] != '0) begin
						slot_q <= lhead_q[scan_lv];
						state_q <= S_RRD;
					end else begin
						scan_q <= scan_q - 1'b1;
					end
				end
				S_RRD: state_q <= S_RWR;
				S_RWR: begin
					lhead_q[scan_lv] <= link_rd_q;
					lcount_q[scan_lv] <= lcount_q[scan_lv] - 1'b1;
					free_head_q <= slot_q;
					held_q <= held_q - 1'b1;
					cursor_q <= scan_q;
					res_q.status <= ST_OK;
					res_q.handle_out <= handle_rd_q;
					res_q.prio_out <= 4'(scan_lv);
					res_q.occupancy <= 9'(held_q - 1'b1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`PMQ_ASSERT_IMP(a_ready_idle, clk, arst_n, in_ch.ready, state_q == S_IDLE)
	`PMQ_ASSERT_IMP(a_held_cap, clk, arst_n, 1'b1, held_q <= CW'(DEPTH))
	`PMQ_ASSERT_NEXT(a_done_valid, clk, arst_n, state_q == S_DONE, res_valid_q)
	`PMQ_ASSERT_NEXT(a_out_hold, clk, arst_n, res_valid_q && !out_ch.ready, res_valid_q && $stable(out_q))
endmodule
